// ===== src/esa_pkg.sv =====
// Shared constants, codes and types of the entity slot allocator.
`timescale 1ns / 1ps

package esa_pkg;

   localparam int MAX_SLOTS = 1024;
   localparam int MAX_TYPES = 32;
   localparam int IDX_W     = 10;
   localparam int GEN_W     = 16;
   localparam int MASK_W    = 32;
   localparam int TYPE_W    = 5;
   localparam int FUNC_W    = 3;
   localparam int STATUS_W  = 3;
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

   // Component-type bits that exist; higher bits of a find mask are dropped.
   localparam logic [MASK_W-1:0] TYPE_MASK = MASK_W'((65'd1 << MAX_TYPES) - 65'd1);

   typedef enum logic [FUNC_W-1:0] {
      FN_CREATE  = 3'd0,
      FN_DESTROY = 3'd1,
      FN_ADD     = 3'd2,
      FN_REMOVE  = 3'd3,
      FN_QUERY   = 3'd4,
      FN_FIND    = 3'd5
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_INVALID  = 3'd1,
      ST_FULL     = 3'd2,
      ST_PRESENT  = 3'd3,
      ST_ABSENT   = 3'd4,
      ST_NOTFOUND = 3'd5
   } status_type;

   typedef struct packed {
      logic [GEN_W-1:0]  gen;
      logic [MASK_W-1:0] mask;
   } slot_entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      slot_entry_type   data;
   } slot_wr_type;

   typedef struct packed {
      status_type        status;
      logic [IDX_W-1:0]  index;
      logic [GEN_W-1:0]  gen;
      logic [MASK_W-1:0] mask;
   } result_type;

endpackage

// ===== src/esa_slot_store.sv =====
// Slot memory holding each slot's generation and component mask.
`timescale 1ns / 1ps

module esa_slot_store
   import esa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [IDX_W-1:0] rd_addr,
   input  slot_wr_type    wr,
   output slot_entry_type rd_data
);

   slot_entry_type mem [MAX_SLOTS];
   slot_entry_type mem_q_ff;
   logic           root_rd_ff;
   logic           root_valid_ff;
   logic           root_valid_in;

   // Slots above the high-water index are zeroed when they are created, so
   // only the root slot, which exists from reset, needs its own valid flag.
   assign root_valid_in = root_valid_ff | (wr.en && (wr.addr == '0));
   assign rd_data       = (root_rd_ff && !root_valid_ff) ? '0 : mem_q_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      mem_q_ff   <= mem[rd_addr];
      root_rd_ff <= (rd_addr == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_valid_ff <= 1'b0;
      end else begin
         root_valid_ff <= root_valid_in;
      end
   end

endmodule

// ===== src/entity_slot_allocator_core.sv =====
// Top level of the entity slot allocator: handle table, free stack and control.
`timescale 1ns / 1ps

// The block keeps a table of generational handles (slot index plus
// generation). Each item on the request channel (req_valid / req_stall)
// carries one operation: create, destroy, add or remove a component bit,
// query a mask, or find the first slot whose mask covers a required mask.
// Each item produces exactly one item on the response channel
// (rsp_valid / rsp_stall) with a status and the index, generation and mask.
// One item is worked on at a time; req_stall is low only while the block
// waits for a new item. The slot memory is read at the accepting edge and
// written back at the next edge, where the response register also loads
// (the holding register instead while the receiver stalls). Create from
// the free stack reads the slot of the popped index first, and a find checks
// one slot per cycle. Each item finishes its write back before the next item
// issues its read, so accesses never overlap. The response sits in an output
// register; while the receiver stalls, the block finishes the next item and
// parks its result in a holding register. Synchronous reset empties the free
// stack, leaves only the root slot with generation 0 and an empty mask, and
// drops any pending response. No memory clearing pass is needed: slots are
// zeroed as the high-water mark grows.

module entity_slot_allocator_core
   import esa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [IDX_W-1:0]    req_index,
   input  logic [GEN_W-1:0]    req_generation,
   input  logic [TYPE_W-1:0]   req_comp_type,
   input  logic [MASK_W-1:0]   req_comp_mask,
   input  logic [IDX_W-1:0]    req_search_from,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [IDX_W-1:0]    rsp_out_index,
   output logic [GEN_W-1:0]    rsp_out_generation,
   output logic [MASK_W-1:0]   rsp_out_mask
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_LOAD = 4'b0100,
      S_WAIT = 4'b1000
   } state_type;

   state_type         state_ff, state_in;

   // Captured request fields.
   logic [FUNC_W-1:0] func_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [GEN_W-1:0]  gen_ff;
   logic [TYPE_W-1:0] typ_ff;
   logic [MASK_W-1:0] need_ff;

   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [IDX_W-1:0]  pick_ff, pick_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  high_ff, high_in;

   result_type        hold_ff, hold_in;
   result_type        rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Free stack memory.
   logic [IDX_W-1:0]  stk_mem [MAX_SLOTS];
   logic [IDX_W-1:0]  stk_q_ff;
   logic [CNT_W-1:0]  cnt_dec;
   logic              stk_we;

   // Slot memory ports.
   logic [IDX_W-1:0]  slot_rd_addr;
   slot_wr_type       slot_wr;
   slot_entry_type    slot_rd;

   logic              accept;
   logic              out_free;
   logic [IDX_W-1:0]  start_idx;
   logic              in_table;
   logic              ok_handle;
   logic              type_bad;
   logic [MASK_W-1:0] type_bit;
   logic [IDX_W-1:0]  pop_idx;
   logic              fin;
   result_type        fin_res;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign start_idx = (req_search_from == '0) ? IDX_W'(1) : req_search_from;
   assign in_table  = (idx_ff <= high_ff);
   assign ok_handle = in_table && (slot_rd.gen == gen_ff);
   assign type_bad  = ({1'b0, typ_ff} >= (TYPE_W + 1)'(MAX_TYPES));
   assign type_bit  = MASK_W'(1) << typ_ff;
   assign cnt_dec   = cnt_ff - CNT_W'(1);

   // A popped index out of the table range falls back to the root slot.
   assign pop_idx = (CNT_W'(stk_q_ff) >= CNT_W'(MAX_SLOTS)) ? '0 : stk_q_ff;

   esa_slot_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (slot_rd_addr),
      .wr      (slot_wr),
      .rd_data (slot_rd)
   );

   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      pick_in        = pick_ff;
      cnt_in         = cnt_ff;
      high_in        = high_ff;
      hold_in        = hold_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      slot_rd_addr   = idx_ff;
      slot_wr        = '0;
      stk_we         = 1'b0;
      fin            = 1'b0;
      fin_res.status = ST_OK;
      fin_res.index  = '0;
      fin_res.gen    = '0;
      fin_res.mask   = '0;

      case (state_ff)
         S_IDLE: begin
            // The slot read for the new item is issued straight from the ports.
            slot_rd_addr = (req_func == FN_FIND) ? start_idx : req_index;
            if (accept) begin
               scan_in  = start_idx;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            case (func_type'(func_ff))
               FN_CREATE: begin
                  if (cnt_ff != '0) begin
                     // Reuse the most recently freed slot; fetch its entry.
                     cnt_in       = cnt_dec;
                     pick_in      = pop_idx;
                     slot_rd_addr = pop_idx;
                     state_in     = S_LOAD;
                  end else if (high_ff != IDX_W'(MAX_SLOTS - 1)) begin
                     high_in        = high_ff + IDX_W'(1);
                     slot_wr.en     = 1'b1;
                     slot_wr.addr   = high_ff + IDX_W'(1);
                     fin            = 1'b1;
                     fin_res.index  = high_ff + IDX_W'(1);
                  end else begin
                     fin            = 1'b1;
                     fin_res.status = ST_FULL;
                  end
               end

               FN_DESTROY: begin
                  fin = 1'b1;
                  if (!ok_handle) begin
                     fin_res.status = ST_INVALID;
                  end else begin
                     slot_wr.en       = 1'b1;
                     slot_wr.addr     = idx_ff;
                     slot_wr.data.gen = slot_rd.gen + GEN_W'(1);
                     if (cnt_ff < CNT_W'(MAX_SLOTS)) begin
                        stk_we = 1'b1;
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
               end

               FN_ADD, FN_REMOVE: begin
                  fin          = 1'b1;
                  slot_wr.addr = idx_ff;
                  slot_wr.data = slot_rd;
                  if (!in_table || type_bad) begin
                     fin_res.status = ST_INVALID;
                  end else if (func_ff == FN_ADD) begin
                     if ((slot_rd.mask & type_bit) != '0) begin
                        fin_res.status = ST_PRESENT;
                     end else begin
                        slot_wr.en        = 1'b1;
                        slot_wr.data.mask = slot_rd.mask | type_bit;
                     end
                  end else begin
                     if ((slot_rd.mask & type_bit) == '0) begin
                        fin_res.status = ST_ABSENT;
                     end else begin
                        slot_wr.en        = 1'b1;
                        slot_wr.data.mask = slot_rd.mask & ~type_bit;
                     end
                  end
               end

               FN_QUERY: begin
                  fin = 1'b1;
                  if (ok_handle) begin
                     fin_res.mask = slot_rd.mask;
                  end else begin
                     fin_res.status = ST_INVALID;
                  end
               end

               FN_FIND: begin
                  // One slot per cycle: the read of the next slot is issued
                  // while the current one is checked.
                  if (scan_ff > high_ff) begin
                     fin            = 1'b1;
                     fin_res.status = ST_NOTFOUND;
                  end else if ((need_ff & slot_rd.mask) == need_ff) begin
                     fin           = 1'b1;
                     fin_res.index = scan_ff;
                     fin_res.gen   = slot_rd.gen;
                     fin_res.mask  = slot_rd.mask;
                  end else if (scan_ff == high_ff) begin
                     fin            = 1'b1;
                     fin_res.status = ST_NOTFOUND;
                  end else begin
                     scan_in      = scan_ff + IDX_W'(1);
                     slot_rd_addr = scan_ff + IDX_W'(1);
                  end
               end

               default: begin
                  fin            = 1'b1;
                  fin_res.status = ST_INVALID;
               end
            endcase
         end

         S_LOAD: begin
            fin           = 1'b1;
            fin_res.index = pick_ff;
            fin_res.gen   = slot_rd.gen;
            fin_res.mask  = slot_rd.mask;
         end

         S_WAIT: begin
            if (out_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A finished item goes to the output register, or waits if it is full.
      if (fin) begin
         if (out_free) begin
            rsp_in       = fin_res;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            hold_in  = fin_res;
            state_in = S_WAIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         high_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         idx_ff  <= req_index;
         gen_ff  <= req_generation;
         typ_ff  <= req_comp_type;
         need_ff <= req_comp_mask & TYPE_MASK;
      end
      scan_ff <= scan_in;
      pick_ff <= pick_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   // Free stack: the top entry is read continuously, whatever the state.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[cnt_ff[IDX_W-1:0]] <= idx_ff;
      end
      stk_q_ff <= stk_mem[cnt_dec[IDX_W-1:0]];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_out_index      = rsp_ff.index;
   assign rsp_out_generation = rsp_ff.gen;
   assign rsp_out_mask       = rsp_ff.mask;

endmodule

// ===== src/esa_checker.sv =====
// Port-level checks of the entity slot allocator, bound to the top level.
`timescale 1ns / 1ps

module esa_checker
   import esa_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [FUNC_W-1:0]   req_func,
   input logic [IDX_W-1:0]    req_index,
   input logic [GEN_W-1:0]    req_generation,
   input logic [TYPE_W-1:0]   req_comp_type,
   input logic [MASK_W-1:0]   req_comp_mask,
   input logic [IDX_W-1:0]    req_search_from,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [IDX_W-1:0]    rsp_out_index,
   input logic [GEN_W-1:0]    rsp_out_generation,
   input logic [MASK_W-1:0]   rsp_out_mask
);

   // A stalled response item holds its place and its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_index) && $stable(rsp_out_generation)
         && $stable(rsp_out_mask))
      else $error("response item changed while stalled");

   // A failed operation reports nothing but its status.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         (rsp_out_index == '0) && (rsp_out_generation == '0) && (rsp_out_mask == '0))
      else $error("failed operation returned nonzero fields");

   // One item at a time: the request side closes after an acceptance.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while one is in work");

   // Reset drops any pending response.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind entity_slot_allocator_core esa_checker u_esa_checker (.*);
